@@ rtl/ouart_pkg.sv @@
package ouart_pkg;

  localparam int unsigned DataBits     = 8;
  localparam int unsigned CountW       = 16;
  localparam int unsigned BitCntW      = 4;
  localparam int unsigned MinRecheckDiv = 3;
  localparam logic [7:0]  DivReset     = 8'd6;

  typedef struct packed {
    logic                valid;
    logic [DataBits-1:0] rx_byte;
    logic                framing_error;
    logic [CountW-1:0]   error_total;
  } ouart_res_t;

endpackage

@@ rtl/ouart_rx_core.sv @@
module ouart_rx_core (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    step,
  input  logic                    sample,
  input  logic [7:0]              bit_divisor,
  output ouart_pkg::ouart_res_t   res
);
  import ouart_pkg::*;

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_START = 3'd1;
  localparam logic [2:0] PH_BITS  = 3'd2;
  localparam logic [2:0] PH_STOP  = 3'd3;
  localparam logic [2:0] PH_WAIT  = 3'd4;

  logic [2:0]          rx_phase_r,    rx_phase_nxt;
  logic [7:0]          sample_wait_r, sample_wait_nxt;
  logic [DataBits-1:0] shift_byte_r,  shift_byte_nxt;
  logic [BitCntW-1:0]  bits_taken_r,  bits_taken_nxt;
  logic [CountW-1:0]   err_cnt_r,     err_cnt_nxt;
  logic [7:0]          full_wait;
  logic [7:0]          half_wait;

  assign full_wait = bit_divisor - 8'd1;
  assign half_wait = {1'b0, bit_divisor[7:1]} - 8'd1;

  always_comb begin
    rx_phase_nxt    = rx_phase_r;
    sample_wait_nxt = sample_wait_r;
    shift_byte_nxt  = shift_byte_r;
    bits_taken_nxt  = bits_taken_r;
    err_cnt_nxt     = err_cnt_r;
    res             = '0;
    if (sample_wait_r != 8'd0) begin
      sample_wait_nxt = sample_wait_r - 8'd1;
    end else begin
      unique case (rx_phase_r)
        PH_IDLE: begin
          if (!sample) begin
            if (bit_divisor < 8'(MinRecheckDiv)) begin
              sample_wait_nxt = '0;
              shift_byte_nxt  = '0;
              bits_taken_nxt  = '0;
              rx_phase_nxt    = PH_BITS;
            end else begin
              sample_wait_nxt = half_wait;
              rx_phase_nxt    = PH_START;
            end
          end
        end
        PH_START: begin
          if (sample) begin
            rx_phase_nxt = PH_IDLE;
          end else begin
            sample_wait_nxt = full_wait;
            shift_byte_nxt  = '0;
            bits_taken_nxt  = '0;
            rx_phase_nxt    = PH_BITS;
          end
        end
        PH_BITS: begin
          shift_byte_nxt  = {sample, shift_byte_r[DataBits-1:1]};
          bits_taken_nxt  = bits_taken_r + 1'b1;
          // count includes this bit; the eighth one moves on to the stop bit
          if (bits_taken_nxt >= BitCntW'(DataBits)) rx_phase_nxt = PH_STOP;
          sample_wait_nxt = full_wait;
        end
        PH_STOP: begin
          res.valid = 1'b1;
          if (sample) begin
            res.rx_byte  = shift_byte_r;
            rx_phase_nxt = PH_IDLE;
          end else begin
            err_cnt_nxt       = err_cnt_r + 1'b1;
            res.framing_error = 1'b1;
            rx_phase_nxt      = PH_WAIT;
          end
          res.error_total = err_cnt_nxt;
        end
        default: begin
          if (sample) rx_phase_nxt = PH_IDLE;
        end
      endcase
    end
    if (!step) res.valid = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_phase_r    <= PH_IDLE;
      sample_wait_r <= '0;
      shift_byte_r  <= '0;
      bits_taken_r  <= '0;
      err_cnt_r     <= '0;
    end else if (step) begin
      rx_phase_r    <= rx_phase_nxt;
      sample_wait_r <= sample_wait_nxt;
      shift_byte_r  <= shift_byte_nxt;
      bits_taken_r  <= bits_taken_nxt;
      err_cnt_r     <= err_cnt_nxt;
    end
  end

endmodule

@@ rtl/oversampled_uart_receiver.sv @@
// 8N1 UART receiver fed one line sample per beat (one beat per oversampling
// tick), LSB first, bit time = cfg bit_divisor ticks (reset 6). Every sample
// beat is handled in the cycle it is accepted, so the input takes one beat
// per clock while in_tready is high. A result beat comes out at each
// stop-bit sample: the byte with tuser low, or tuser high (framing error,
// byte zero) plus the wrapping 16-bit error count. A two-deep output stage
// (register plus skid) keeps in_tready high unless two results are backed
// up; in_tready only drops while the skid entry is occupied.
module oversampled_uart_receiver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] rx_sample, rest zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] rx_byte, [23:8] error_total
  output logic        out_tuser,  // [0] framing_error
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data    // bit_divisor
);
  import ouart_pkg::*;

  logic [7:0] bit_div_r;
  logic       in_beat;
  ouart_res_t res;
  ouart_res_t out_r;
  ouart_res_t skid_r;

  assign cfg_ready = 1'b1;
  assign in_tready = !skid_r.valid;
  assign in_beat   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) bit_div_r <= DivReset;
    else if (cfg_valid && cfg_ready) bit_div_r <= cfg_data;
  end

  ouart_rx_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (in_beat),
    .sample      (in_tdata[0]),
    .bit_divisor (bit_div_r),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.valid  <= 1'b0;
      skid_r.valid <= 1'b0;
    end else if (out_r.valid && !out_tready) begin
      if (res.valid) skid_r <= res;
    end else if (skid_r.valid) begin
      out_r        <= skid_r;
      skid_r.valid <= 1'b0;
    end else begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_r.valid;
  assign out_tdata  = {out_r.error_total, out_r.rx_byte};
  assign out_tuser  = out_r.framing_error;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_r.valid |-> out_r.valid)
    else $error("skid entry held with empty output register");

  a_err_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[7:0] == 8'd0)
    else $error("framing error result carries nonzero byte");

  a_stall_captured: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid && out_r.valid && !out_tready |=> skid_r.valid)
    else $error("result lost while output stalled");
`endif

endmodule
